// ===== sv/ctd_pkg.sv =====
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared widths, types and arithmetic helpers for the conservative triangle
// dilation core.
// ----------------------------------------------------------------------------
package ctd_pkg;

   // Field and datapath widths
   localparam int V_W      = 16;            // vertex coordinate, Q8.8
   localparam int HP_W     = 15;            // half pixel register
   localparam int P_W      = 33;            // plane a, b and raw cross term
   localparam int PMAG_W   = 32;            // |a|, |b|
   localparam int PRD_W    = HP_W + PMAG_W; // h * |a|
   localparam int DIL_W    = PRD_W + 1;     // hx*|a| + hy*|b|
   localparam int PZ_W     = 50;            // dilated plane offset
   localparam int PZ_LO_W  = 25;
   localparam int PZ_HI_W  = PZ_W - PZ_LO_W;
   localparam int HI_PRD_W = P_W + PZ_HI_W;
   localparam int LO_PRD_W = P_W + PZ_LO_W + 1;
   localparam int Z_PRD_W  = 2 * P_W;
   localparam int XY_W     = 84;            // intersection x, y terms
   localparam int Z_W      = 67;            // intersection z term
   localparam int Q_W      = 32;            // Q16.16 result
   localparam int FRAC_SH  = 8;             // extra scale in the quotient

   localparam int REQ_W    = 9 * V_W;
   localparam int RSP_W    = 6 * Q_W;
   localparam int CSR_IDX_W = 2;

   localparam int PRE_STAGES = 4;           // plane and intersection stages
   localparam int DIV_STAGES = Q_W;         // one quotient bit per stage

   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [HP_W-1:0] HP_RESET = HP_W'(26);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_PIXEL_X = 2'd0,
      CSR_HALF_PIXEL_Y = 2'd1
   } csr_index_type;

   // Classified triangle handed from the front end to the back end
   typedef struct packed {
      logic                   s_pos;
      logic                   s_neg;
      logic [2:0][P_W-1:0]    px;
      logic [2:0][P_W-1:0]    py;
      logic [2:0][P_W-1:0]    cc;
   } entry_type;

   // p times the upper, signed part of a plane offset
   function automatic logic signed [HI_PRD_W-1:0] mul_hi(input logic [P_W-1:0] p,
                                                         input logic [PZ_W-1:0] pz);
      mul_hi = HI_PRD_W'($signed(p)) * HI_PRD_W'($signed(pz[PZ_W-1:PZ_LO_W]));
   endfunction

   // p times the lower, unsigned part of a plane offset
   function automatic logic signed [LO_PRD_W-1:0] mul_lo(input logic [P_W-1:0] p,
                                                         input logic [PZ_W-1:0] pz);
      mul_lo = LO_PRD_W'($signed(p)) * LO_PRD_W'($signed({1'b0, pz[PZ_LO_W-1:0]}));
   endfunction

   function automatic logic signed [Z_PRD_W-1:0] mul_z(input logic [P_W-1:0] a,
                                                       input logic [P_W-1:0] b);
      mul_z = Z_PRD_W'($signed(a)) * Z_PRD_W'($signed(b));
   endfunction

   // Recombine the two partial products of one split multiply
   function automatic logic signed [XY_W-1:0] merge_parts(
      input logic signed [HI_PRD_W-1:0] hi,
      input logic signed [LO_PRD_W-1:0] lo);
      logic signed [XY_W-1:0] h;
      logic signed [XY_W-1:0] l;
      h = XY_W'(hi);
      l = XY_W'(lo);
      merge_parts = (h <<< PZ_LO_W) + l;
   endfunction

endpackage

// ===== sv/ctd_front.sv =====
// ----------------------------------------------------------------------------
// ctd_front
// Classifies an incoming triangle: orientation sign and the three undilated
// edge planes (a, b and raw offset term).
// ----------------------------------------------------------------------------
module ctd_front (
   input  logic [ctd_pkg::REQ_W-1:0] req_data,
   output ctd_pkg::entry_type        entry
);
   import ctd_pkg::*;

   logic signed [V_W-1:0]   vx [3];
   logic signed [V_W-1:0]   vy [3];
   logic signed [V_W-1:0]   vw [3];
   logic signed [V_W:0]     dx1, dy1, dx2, dy2;
   logic signed [2*V_W+2:0] nz;

   // Unpack vertices and form the edge planes
   for (genvar gi = 0; gi < 3; gi++) begin : g_plane
      localparam int GJ = (gi + 2) % 3;
      assign vx[gi] = req_data[(3*gi)*V_W +: V_W];
      assign vy[gi] = req_data[(3*gi+1)*V_W +: V_W];
      assign vw[gi] = req_data[(3*gi+2)*V_W +: V_W];
      assign entry.px[gi] = P_W'(vy[gi]) * P_W'(vw[GJ]) - P_W'(vw[gi]) * P_W'(vy[GJ]);
      assign entry.py[gi] = P_W'(vw[gi]) * P_W'(vx[GJ]) - P_W'(vx[gi]) * P_W'(vw[GJ]);
      assign entry.cc[gi] = P_W'(vx[gi]) * P_W'(vy[GJ]) - P_W'(vy[gi]) * P_W'(vx[GJ]);
   end

   // Orientation from the screen-space cross product
   assign dx1 = $signed({vx[1][V_W-1], vx[1]}) - $signed({vx[0][V_W-1], vx[0]});
   assign dy1 = $signed({vy[1][V_W-1], vy[1]}) - $signed({vy[0][V_W-1], vy[0]});
   assign dx2 = $signed({vx[2][V_W-1], vx[2]}) - $signed({vx[0][V_W-1], vx[0]});
   assign dy2 = $signed({vy[2][V_W-1], vy[2]}) - $signed({vy[0][V_W-1], vy[0]});
   assign nz  = (2*V_W+3)'(dx1) * (2*V_W+3)'(dy2) - (2*V_W+3)'(dy1) * (2*V_W+3)'(dx2);

   assign entry.s_neg = nz[2*V_W+2];
   assign entry.s_pos = !nz[2*V_W+2] && (nz != '0);

endmodule

// ===== sv/ctd_queue.sv =====
// ----------------------------------------------------------------------------
// ctd_queue
// Small FIFO between the classifying front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module ctd_queue #(
   parameter int DEPTH = ctd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ctd_pkg::entry_type wdata,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output ctd_pkg::entry_type rdata
);
   import ctd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");

endmodule

// ===== sv/ctd_div.sv =====
// ----------------------------------------------------------------------------
// ctd_div
// Pipelined restoring divider: saturated Q16.16 value of 256*num/den,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module ctd_div (
   input  logic                               clock,
   input  logic                               adv,
   input  logic signed [ctd_pkg::XY_W-1:0]    num,
   input  logic signed [ctd_pkg::Z_W-1:0]     den,
   output logic [ctd_pkg::Q_W-1:0]            quo
);
   import ctd_pkg::*;

   localparam int NUM_W = XY_W + FRAC_SH;

   logic [XY_W-1:0]  nmag_in;
   logic [Z_W-1:0]   dmag_in;
   logic [NUM_W-1:0] n_in;

   logic [Z_W-1:0]   r_ff   [DIV_STAGES+1];
   logic [Q_W-1:0]   nl_ff  [DIV_STAGES+1];
   logic [Q_W-1:0]   q_ff   [DIV_STAGES+1];
   logic [Z_W-1:0]   d_ff   [DIV_STAGES+1];
   logic             neg_ff [DIV_STAGES+1];
   logic             ovf_ff [DIV_STAGES+1];

   logic [Q_W-1:0]   limit;
   logic [Q_W-1:0]   qsat;

   // Take magnitudes and check the quotient fits 32 bits
   assign nmag_in = num[XY_W-1] ? XY_W'(-num) : XY_W'(num);
   assign dmag_in = den[Z_W-1]  ? Z_W'(-den)  : Z_W'(den);
   assign n_in    = {nmag_in, FRAC_SH'(0)};

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0]   <= Z_W'(n_in[NUM_W-1:Q_W]);
         nl_ff[0]  <= n_in[Q_W-1:0];
         q_ff[0]   <= '0;
         d_ff[0]   <= dmag_in;
         neg_ff[0] <= num[XY_W-1] ^ den[Z_W-1];
         ovf_ff[0] <= Z_W'(n_in[NUM_W-1:Q_W]) >= dmag_in;
      end
   end

   // One restoring step per stage
   for (genvar gk = 0; gk < DIV_STAGES; gk++) begin : g_step
      logic [Z_W:0] t;
      logic         ge;
      assign t  = {r_ff[gk], nl_ff[gk][Q_W-1]};
      assign ge = t >= {1'b0, d_ff[gk]};
      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[gk+1]   <= ge ? Z_W'(t - {1'b0, d_ff[gk]}) : Z_W'(t);
            nl_ff[gk+1]  <= nl_ff[gk] << 1;
            q_ff[gk+1]   <= {q_ff[gk][Q_W-2:0], ge};
            d_ff[gk+1]   <= d_ff[gk];
            neg_ff[gk+1] <= neg_ff[gk];
            ovf_ff[gk+1] <= ovf_ff[gk];
         end
      end
   end

   // Saturate and apply the sign
   assign limit = neg_ff[DIV_STAGES] ? {1'b1, (Q_W-1)'(0)} : {1'b0, {(Q_W-1){1'b1}}};
   assign qsat  = (ovf_ff[DIV_STAGES] || (q_ff[DIV_STAGES] > limit)) ? limit
                                                                     : q_ff[DIV_STAGES];
   assign quo   = neg_ff[DIV_STAGES] ? Q_W'(-qsat) : qsat;

endmodule

// ===== sv/ctd_back.sv =====
// ----------------------------------------------------------------------------
// ctd_back
// Dilates the edge planes, intersects neighbors and divides to screen space.
// The whole pipeline advances together whenever the output register is free.
// ----------------------------------------------------------------------------
module ctd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ctd_pkg::HP_W-1:0]    half_pixel_x,
   input  logic [ctd_pkg::HP_W-1:0]    half_pixel_y,
   input  ctd_pkg::entry_type          head,
   input  logic                        head_valid,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ctd_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                        rsp_tuser
);
   import ctd_pkg::*;

   localparam int PIPE_N = PRE_STAGES + 1 + DIV_STAGES;

   logic                       adv;
   logic [PIPE_N-1:0]          vld_ff;
   logic [DIV_STAGES:0]        flt_ff;
   logic                       fault_in;

   entry_type                  b0_ent_ff;
   logic [PRD_W-1:0]           dx_in [3], dx_ff [3];
   logic [PRD_W-1:0]           dy_in [3], dy_ff [3];

   entry_type                  b1_ent_ff;
   logic signed [PZ_W-1:0]     pz_in [3], pz_ff [3];

   logic signed [HI_PRD_W-1:0] xah_ff [3], xbh_ff [3], yah_ff [3], ybh_ff [3];
   logic signed [LO_PRD_W-1:0] xal_ff [3], xbl_ff [3], yal_ff [3], ybl_ff [3];
   logic signed [Z_PRD_W-1:0]  za_ff [3], zb_ff [3];

   logic signed [XY_W-1:0]     x_ff [3], y_ff [3];
   logic signed [Z_W-1:0]      z_ff [3];

   logic [Q_W-1:0]             qx [3], qy [3];
   logic [RSP_W-1:0]           rsp_data_in;

   logic                       rsp_valid_ff;
   logic [RSP_W-1:0]           rsp_data_ff;
   logic                       rsp_flt_ff;

   assign adv = !rsp_valid_ff || rsp_tready;
   assign pop = adv && head_valid;

   for (genvar gi = 0; gi < 3; gi++) begin : g_lane
      localparam int GJ = (gi + 1) % 3;
      logic [PMAG_W-1:0]       ax, ay;
      logic [DIL_W-1:0]        dil;
      logic signed [PZ_W-1:0]  cs;

      // Scale plane normals by the half pixel
      assign ax = head.px[gi][P_W-1] ? PMAG_W'(-$signed(head.px[gi]))
                                     : PMAG_W'(head.px[gi]);
      assign ay = head.py[gi][P_W-1] ? PMAG_W'(-$signed(head.py[gi]))
                                     : PMAG_W'(head.py[gi]);
      assign dx_in[gi] = PRD_W'(half_pixel_x) * PRD_W'(ax);
      assign dy_in[gi] = PRD_W'(half_pixel_y) * PRD_W'(ay);

      // Push the plane offset out by the dilation
      assign dil = DIL_W'(dx_ff[gi]) + DIL_W'(dy_ff[gi]);
      assign cs  = PZ_W'($signed(b0_ent_ff.cc[gi])) <<< FRAC_SH;
      assign pz_in[gi] = b0_ent_ff.s_pos ? cs - $signed(PZ_W'(dil)) :
                         b0_ent_ff.s_neg ? cs + $signed(PZ_W'(dil)) : cs;

      always_ff @(posedge clock) begin
         if (adv) begin
            dx_ff[gi] <= dx_in[gi];
            dy_ff[gi] <= dy_in[gi];
            pz_ff[gi] <= pz_in[gi];
            // Partial products of the plane intersections
            xah_ff[gi] <= mul_hi(b1_ent_ff.py[gi], pz_ff[GJ]);
            xal_ff[gi] <= mul_lo(b1_ent_ff.py[gi], pz_ff[GJ]);
            xbh_ff[gi] <= mul_hi(b1_ent_ff.py[GJ], pz_ff[gi]);
            xbl_ff[gi] <= mul_lo(b1_ent_ff.py[GJ], pz_ff[gi]);
            yah_ff[gi] <= mul_hi(b1_ent_ff.px[GJ], pz_ff[gi]);
            yal_ff[gi] <= mul_lo(b1_ent_ff.px[GJ], pz_ff[gi]);
            ybh_ff[gi] <= mul_hi(b1_ent_ff.px[gi], pz_ff[GJ]);
            ybl_ff[gi] <= mul_lo(b1_ent_ff.px[gi], pz_ff[GJ]);
            za_ff[gi]  <= mul_z(b1_ent_ff.px[gi], b1_ent_ff.py[GJ]);
            zb_ff[gi]  <= mul_z(b1_ent_ff.py[gi], b1_ent_ff.px[GJ]);
            // Sum partial products into homogeneous intersections
            x_ff[gi] <= merge_parts(xah_ff[gi], xal_ff[gi])
                        - merge_parts(xbh_ff[gi], xbl_ff[gi]);
            y_ff[gi] <= merge_parts(yah_ff[gi], yal_ff[gi])
                        - merge_parts(ybh_ff[gi], ybl_ff[gi]);
            z_ff[gi] <= Z_W'(za_ff[gi]) - Z_W'(zb_ff[gi]);
         end
      end

      ctd_div u_div_x (
         .clock (clock),
         .adv   (adv),
         .num   (x_ff[gi]),
         .den   (z_ff[gi]),
         .quo   (qx[gi])
      );

      ctd_div u_div_y (
         .clock (clock),
         .adv   (adv),
         .num   (y_ff[gi]),
         .den   (z_ff[gi]),
         .quo   (qy[gi])
      );

      assign rsp_data_in[(2*gi)*Q_W +: Q_W]   = qx[gi];
      assign rsp_data_in[(2*gi+1)*Q_W +: Q_W] = qy[gi];
   end

   assign fault_in = (z_ff[0] == '0) || (z_ff[1] == '0) || (z_ff[2] == '0);

   // Carry entries and the fault flag down the pipeline
   always_ff @(posedge clock) begin
      if (adv) begin
         b0_ent_ff <= head;
         b1_ent_ff <= b0_ent_ff;
         flt_ff    <= {flt_ff[DIV_STAGES-1:0], fault_in};
      end
   end

   // Advance stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[PIPE_N-2:0], head_valid};
         rsp_valid_ff <= vld_ff[PIPE_N-1];
      end
   end

   // Output register: zero the coordinates on a divide fault
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= flt_ff[DIV_STAGES] ? '0 : rsp_data_in;
         rsp_flt_ff  <= flt_ff[DIV_STAGES];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flt_ff;

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("faulted result carries nonzero coordinates");

   a_pop_only_on_adv: assert property (@(posedge clock) disable iff (reset)
      pop |=> vld_ff[0])
      else $error("popped entry did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while output stalled");

endmodule

// ===== sv/conservative_triangle_dilation_core.sv =====
// ----------------------------------------------------------------------------
// conservative_triangle_dilation_core
// Path from an accepted triangle to rsp_tvalid: queue write, four
//   plane/intersection stages, divider setup, 32 divider stages, output.
// Throughput: one triangle per cycle while rsp_tready does not stall the output.
// Reset: synchronous, active high; clears the queue, stage valids and output,
//   and returns both half pixel registers to 26.
// ----------------------------------------------------------------------------
module conservative_triangle_dilation_core #(
   parameter int QUEUE_DEPTH = ctd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // v0_x, v0_y, v0_w, v1_x, v1_y, v1_w, v2_x, v2_y, v2_w (16 bits each)
   input  logic [ctd_pkg::REQ_W-1:0]      req_tdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // out0_x, out0_y, out1_x, out1_y, out2_x, out2_y (32 bits each)
   output logic [ctd_pkg::RSP_W-1:0]      rsp_tdata,
   // divide_fault
   output logic                           rsp_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ctd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ctd_pkg::HP_W-1:0]       csr_data
);
   import ctd_pkg::*;

   logic [HP_W-1:0] hx_ff, hy_ff;
   entry_type       front_entry;
   entry_type       head;
   logic            full, empty, push, pop;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hx_ff <= HP_RESET;
         hy_ff <= HP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HALF_PIXEL_X: hx_ff <= csr_data;
            CSR_HALF_PIXEL_Y: hy_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_tready = !full;
   assign push       = req_tvalid && req_tready;

   ctd_front u_front (
      .req_data (req_tdata),
      .entry    (front_entry)
   );

   ctd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (front_entry),
      .full  (full),
      .pop   (pop),
      .empty (empty),
      .rdata (head)
   );

   ctd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .half_pixel_x (hx_ff),
      .half_pixel_y (hy_ff),
      .head         (head),
      .head_valid   (!empty),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule
